/* hdl/gsa_pkg.sv */
// ----------------------------------------------------------------------------
// gsa_pkg
// Shared types and constants of the generational slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package gsa_pkg;

  localparam int SLOTS  = 256;
  localparam int IDX_W  = 8;
  localparam int LINK_W = 9;
  localparam int GEN_W  = 8;

  localparam logic [LINK_W-1:0] NONE_IDX   = LINK_W'(SLOTS);
  localparam logic [LINK_W-1:0] SLOTS_FULL = LINK_W'(SLOTS);

  localparam logic [2:0] CMD_ADD    = 3'd0;
  localparam logic [2:0] CMD_REMOVE = 3'd1;
  localparam logic [2:0] CMD_LOOKUP = 3'd2;
  localparam logic [2:0] CMD_NEXT   = 3'd3;
  localparam logic [2:0] CMD_PREV   = 3'd4;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_BAD  = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  // free flag and generation of one slot
  typedef struct packed {
    logic             free;
    logic [GEN_W-1:0] gen;
  } slot_info_t;

endpackage

`default_nettype wire

/* hdl/generational_slot_allocator.sv */
// ----------------------------------------------------------------------------
// generational_slot_allocator
// Pool of slots handed out as index/generation handles, with a free stack and
// an insertion-ordered doubly linked list of live slots held in RAM.
// Result registered after the read-modify-write states of the slot, link and
// stack RAMs: add READ, ADD_GEN, ADD_WR, OUT; remove READ, REM_CHK, REM_LINK,
// OUT (stale remove skips REM_LINK); lookup, links READ, QUERY, OUT; bad
// command, full add READ, OUT. One beat in flight at a time. Reset: a sweep
// over all 256 slots initialises the RAMs; no input beat taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module generational_slot_allocator
  import gsa_pkg::*;
#(
  parameter int PAYLOAD_WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [2:0]               in_command,
  input  wire logic [IDX_W-1:0]         in_slot_index,
  input  wire logic [GEN_W-1:0]         in_handle_generation,
  input  wire logic [PAYLOAD_WIDTH-1:0] in_payload,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [1:0]                    out_status,
  output logic [LINK_W-1:0]             out_result_index,
  output logic [GEN_W-1:0]              out_result_generation,
  output logic [PAYLOAD_WIDTH-1:0]      out_result_payload,
  output logic [LINK_W-1:0]             out_head_index,
  output logic [LINK_W-1:0]             out_tail_index,
  output logic [LINK_W-1:0]             out_live_count
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_READ, S_ADD_GEN, S_ADD_WR, S_REM_CHK, S_REM_LINK, S_QUERY, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  logic [2:0]               cmd_r, cmd_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [GEN_W-1:0]         hgen_r, hgen_nxt;
  logic [PAYLOAD_WIDTH-1:0] pay_r, pay_nxt;
  logic [LINK_W-1:0]        free_top_r, free_top_nxt;
  logic [LINK_W-1:0]        head_r, head_nxt;
  logic [LINK_W-1:0]        tail_r, tail_nxt;
  logic [LINK_W-1:0]        count_r, count_nxt;
  logic [IDX_W-1:0]         init_addr_r, init_addr_nxt;
  logic [IDX_W-1:0]         slot_r, slot_nxt;
  logic [LINK_W-1:0]        nb_next_r, nb_next_nxt;
  logic [LINK_W-1:0]        nb_prev_r, nb_prev_nxt;
  logic [1:0]               res_status_r, res_status_nxt;
  logic [LINK_W-1:0]        res_idx_r, res_idx_nxt;
  logic [GEN_W-1:0]         res_gen_r, res_gen_nxt;
  logic [PAYLOAD_WIDTH-1:0] res_pay_r, res_pay_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [1:0]               out_status_r, out_status_nxt;
  logic [LINK_W-1:0]        out_idx_r, out_idx_nxt;
  logic [GEN_W-1:0]         out_gen_r, out_gen_nxt;
  logic [PAYLOAD_WIDTH-1:0] out_pay_r, out_pay_nxt;
  logic [LINK_W-1:0]        out_head_r, out_head_nxt;
  logic [LINK_W-1:0]        out_tail_r, out_tail_nxt;
  logic [LINK_W-1:0]        out_count_r, out_count_nxt;

  // RAM ports
  logic                     stk_we, info_we, nxt_we, prv_we, pay_we;
  logic [IDX_W-1:0]         stk_waddr, info_waddr, nxt_waddr, prv_waddr;
  logic [IDX_W-1:0]         stk_raddr, info_raddr;
  logic [IDX_W-1:0]         stk_wdata, stk_rdata;
  slot_info_t               info_wdata, info_rdata;
  logic [LINK_W-1:0]        nxt_wdata, nxt_rdata, prv_wdata, prv_rdata;
  logic [PAYLOAD_WIDTH-1:0] pay_rdata;

  logic       handle_ok;
  logic [GEN_W-1:0] gen_inc;

  assign handle_ok = (count_r != '0) && !info_rdata.free && (info_rdata.gen == hgen_r);
  assign gen_inc   = (info_rdata.gen == {GEN_W{1'b1}}) ? GEN_W'(1) : info_rdata.gen + GEN_W'(1);

  assign stk_raddr  = IDX_W'(free_top_r - LINK_W'(1));
  assign info_raddr = (state_r == S_ADD_GEN) ? stk_rdata : idx_r;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    idx_nxt        = idx_r;
    hgen_nxt       = hgen_r;
    pay_nxt        = pay_r;
    free_top_nxt   = free_top_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    init_addr_nxt  = init_addr_r;
    slot_nxt       = slot_r;
    nb_next_nxt    = nb_next_r;
    nb_prev_nxt    = nb_prev_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_gen_nxt    = res_gen_r;
    res_pay_nxt    = res_pay_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_gen_nxt    = out_gen_r;
    out_pay_nxt    = out_pay_r;
    out_head_nxt   = out_head_r;
    out_tail_nxt   = out_tail_r;
    out_count_nxt  = out_count_r;

    stk_we     = 1'b0;
    stk_waddr  = idx_r;
    stk_wdata  = idx_r;
    info_we    = 1'b0;
    info_waddr = idx_r;
    info_wdata = '{free: 1'b1, gen: info_rdata.gen};
    nxt_we     = 1'b0;
    nxt_waddr  = idx_r;
    nxt_wdata  = NONE_IDX;
    prv_we     = 1'b0;
    prv_waddr  = idx_r;
    prv_wdata  = NONE_IDX;
    pay_we     = 1'b0;

    unique case (state_r)
      S_INIT: begin
        stk_we     = 1'b1;
        stk_waddr  = init_addr_r;
        stk_wdata  = ~init_addr_r;
        info_we    = 1'b1;
        info_waddr = init_addr_r;
        info_wdata = '{free: 1'b1, gen: '0};
        nxt_we     = 1'b1;
        nxt_waddr  = init_addr_r;
        prv_we     = 1'b1;
        prv_waddr  = init_addr_r;
        init_addr_nxt = init_addr_r + IDX_W'(1);
        if (init_addr_r == {IDX_W{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_command;
          idx_nxt   = in_slot_index;
          hgen_nxt  = in_handle_generation;
          pay_nxt   = in_payload;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        res_status_nxt = STAT_BAD;
        res_idx_nxt    = NONE_IDX;
        res_gen_nxt    = '0;
        res_pay_nxt    = '0;
        case (cmd_r)
          CMD_ADD: begin
            if (count_r == SLOTS_FULL || free_top_r == '0) begin
              res_status_nxt = STAT_FULL;
              state_nxt      = S_OUT;
            end else begin
              state_nxt = S_ADD_GEN;
            end
          end
          CMD_REMOVE: state_nxt = S_REM_CHK;
          CMD_LOOKUP, CMD_NEXT, CMD_PREV: state_nxt = S_QUERY;
          default: state_nxt = S_OUT;
        endcase
      end
      S_ADD_GEN: begin
        slot_nxt     = stk_rdata;
        free_top_nxt = free_top_r - LINK_W'(1);
        pay_we       = 1'b1;
        nxt_we       = 1'b1;
        nxt_waddr    = stk_rdata;
        state_nxt    = S_ADD_WR;
      end
      S_ADD_WR: begin
        info_we    = 1'b1;
        info_waddr = slot_r;
        info_wdata = '{free: 1'b0, gen: gen_inc};
        prv_we     = 1'b1;
        prv_waddr  = slot_r;
        prv_wdata  = tail_r;
        if (tail_r != NONE_IDX) begin
          nxt_we    = 1'b1;
          nxt_waddr = tail_r[IDX_W-1:0];
          nxt_wdata = {1'b0, slot_r};
        end
        if (head_r == NONE_IDX) begin
          head_nxt = {1'b0, slot_r};
        end
        tail_nxt       = {1'b0, slot_r};
        count_nxt      = count_r + LINK_W'(1);
        res_status_nxt = STAT_OK;
        res_idx_nxt    = {1'b0, slot_r};
        res_gen_nxt    = gen_inc;
        state_nxt      = S_OUT;
      end
      S_REM_CHK: begin
        if (handle_ok) begin
          info_we     = 1'b1;
          nxt_we      = 1'b1;
          prv_we      = 1'b1;
          nb_next_nxt = nxt_rdata;
          nb_prev_nxt = prv_rdata;
          if (free_top_r < SLOTS_FULL) begin
            stk_we       = 1'b1;
            stk_waddr    = free_top_r[IDX_W-1:0];
            free_top_nxt = free_top_r + LINK_W'(1);
          end
          state_nxt = S_REM_LINK;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_REM_LINK: begin
        if (nb_next_r != NONE_IDX) begin
          prv_we    = 1'b1;
          prv_waddr = nb_next_r[IDX_W-1:0];
          prv_wdata = nb_prev_r;
        end
        if (nb_prev_r != NONE_IDX) begin
          nxt_we    = 1'b1;
          nxt_waddr = nb_prev_r[IDX_W-1:0];
          nxt_wdata = nb_next_r;
        end
        if (head_r == {1'b0, idx_r}) begin
          head_nxt = nb_next_r;
        end
        if (tail_r == {1'b0, idx_r}) begin
          tail_nxt = nb_prev_r;
        end
        count_nxt      = count_r - LINK_W'(1);
        res_status_nxt = STAT_OK;
        state_nxt      = S_OUT;
      end
      S_QUERY: begin
        if (cmd_r == CMD_LOOKUP) begin
          if (handle_ok) begin
            res_status_nxt = STAT_OK;
            res_pay_nxt    = pay_rdata;
          end
        end else if (count_r != '0) begin
          res_status_nxt = STAT_OK;
          res_idx_nxt    = (cmd_r == CMD_NEXT) ? nxt_rdata : prv_rdata;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_idx_nxt    = res_idx_r;
          out_gen_nxt    = res_gen_r;
          out_pay_nxt    = res_pay_r;
          out_head_nxt   = head_r;
          out_tail_nxt   = tail_r;
          out_count_nxt  = count_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_addr_r <= '0;
      free_top_r  <= SLOTS_FULL;
      head_r      <= NONE_IDX;
      tail_r      <= NONE_IDX;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_addr_r <= init_addr_nxt;
      free_top_r  <= free_top_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    idx_r        <= idx_nxt;
    hgen_r       <= hgen_nxt;
    pay_r        <= pay_nxt;
    slot_r       <= slot_nxt;
    nb_next_r    <= nb_next_nxt;
    nb_prev_r    <= nb_prev_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_gen_r    <= res_gen_nxt;
    res_pay_r    <= res_pay_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_gen_r    <= out_gen_nxt;
    out_pay_r    <= out_pay_nxt;
    out_head_r   <= out_head_nxt;
    out_tail_r   <= out_tail_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_result_index      = out_idx_r;
  assign out_result_generation = out_gen_r;
  assign out_result_payload    = out_pay_r;
  assign out_head_index        = out_head_r;
  assign out_tail_index        = out_tail_r;
  assign out_live_count        = out_count_r;

  gsa_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_stack_ram (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  gsa_ram #(.WIDTH($bits(slot_info_t)), .DEPTH(SLOTS)) u_info_ram (
    .clk(clk), .we(info_we), .waddr(info_waddr), .wdata(info_wdata),
    .raddr(info_raddr), .rdata(info_rdata)
  );

  gsa_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_next_ram (
    .clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
    .raddr(idx_r), .rdata(nxt_rdata)
  );

  gsa_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_prev_ram (
    .clk(clk), .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
    .raddr(idx_r), .rdata(prv_rdata)
  );

  gsa_ram #(.WIDTH(PAYLOAD_WIDTH), .DEPTH(SLOTS)) u_payload_ram (
    .clk(clk), .we(pay_we), .waddr(stk_rdata), .wdata(pay_r),
    .raddr(idx_r), .rdata(pay_rdata)
  );

endmodule

`default_nettype wire

/* hdl/gsa_ram.sv */
// ----------------------------------------------------------------------------
// gsa_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* tb/tb_generational_slot_allocator.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_generational_slot_allocator
// Drives add, remove, lookup, link-query and reserved beats into the pool,
// predicts every result from a private copy of the pool (free stack, bitmap,
// generations, payloads and live list) and checks each result beat field by
// field, under random idling, a long receiver hold-off and a full pool.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_generational_slot_allocator;
  import gsa_pkg::*;

  localparam logic [2:0] CMD_RSV5 = 3'd5;
  localparam logic [2:0] CMD_RSV6 = 3'd6;
  localparam logic [2:0] CMD_RSV7 = 3'd7;

  typedef struct packed {
    logic [1:0]        status;
    logic [LINK_W-1:0] index;
    logic [GEN_W-1:0]  gen;
    logic [31:0]       payload;
    logic [LINK_W-1:0] head;
    logic [LINK_W-1:0] tail;
    logic [LINK_W-1:0] count;
  } pool_answer_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [2:0]        in_command = CMD_ADD;
  logic [IDX_W-1:0]  in_slot_index = '0;
  logic [GEN_W-1:0]  in_handle_generation = '0;
  logic [31:0]       in_payload = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_status;
  logic [LINK_W-1:0] out_result_index;
  logic [GEN_W-1:0]  out_result_generation;
  logic [31:0]       out_result_payload;
  logic [LINK_W-1:0] out_head_index;
  logic [LINK_W-1:0] out_tail_index;
  logic [LINK_W-1:0] out_live_count;

  generational_slot_allocator #(.PAYLOAD_WIDTH(32)) dut (.*);

  // pool copy
  logic [IDX_W-1:0]  free_stk [SLOTS];
  int                free_top;
  logic              free_map [SLOTS];
  logic [GEN_W-1:0]  gen_tbl  [SLOTS];
  logic [LINK_W-1:0] nxt_tbl  [SLOTS];
  logic [LINK_W-1:0] prv_tbl  [SLOTS];
  logic [31:0]       pay_tbl  [SLOTS];
  logic [LINK_W-1:0] pool_head;
  logic [LINK_W-1:0] pool_tail;
  int                pool_live;

  pool_answer_t answers_due [$];
  int  errors = 0;
  int  beats_sent = 0;
  int  beats_checked = 0;
  int  full_hits = 0;
  int  gen_wraps = 0;
  int  send_idle_pct = 29;
  int  recv_stall_pct = 29;
  int  hold_left = 0;

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  function automatic bit handle_live(logic [IDX_W-1:0] idx, logic [GEN_W-1:0] g);
    return pool_live != 0 && gen_tbl[idx] == g && !free_map[idx];
  endfunction

  task automatic predict_pool(logic [2:0] cmd, logic [IDX_W-1:0] idx,
                              logic [GEN_W-1:0] g, logic [31:0] pay);
    pool_answer_t a;
    logic [IDX_W-1:0]  s;
    logic [LINK_W-1:0] p, n;
    a = '0;
    a.status = STAT_BAD;
    a.index  = NONE_IDX;
    case (cmd)
      CMD_ADD: begin
        if (free_top == 0 || pool_live >= SLOTS) begin
          a.status = STAT_FULL;
          full_hits++;
        end else begin
          free_top--;
          s = free_stk[free_top];
          free_map[s] = 1'b0;
          nxt_tbl[s] = NONE_IDX;
          prv_tbl[s] = NONE_IDX;
          if (pool_head == NONE_IDX) pool_head = LINK_W'(s);
          if (pool_tail == NONE_IDX) begin
            pool_tail = LINK_W'(s);
          end else begin
            nxt_tbl[pool_tail[IDX_W-1:0]] = LINK_W'(s);
            prv_tbl[s] = pool_tail;
            pool_tail = LINK_W'(s);
          end
          pay_tbl[s] = pay;
          if (gen_tbl[s] == 8'hFF) begin
            gen_tbl[s] = 8'd1;
            gen_wraps++;
          end else begin
            gen_tbl[s] = gen_tbl[s] + 8'd1;
          end
          pool_live++;
          a.status = STAT_OK;
          a.index  = LINK_W'(s);
          a.gen    = gen_tbl[s];
        end
      end
      CMD_REMOVE: begin
        if (handle_live(idx, g)) begin
          p = prv_tbl[idx];
          n = nxt_tbl[idx];
          prv_tbl[idx] = NONE_IDX;
          nxt_tbl[idx] = NONE_IDX;
          if (n < SLOTS) prv_tbl[n[IDX_W-1:0]] = p;
          if (p < SLOTS) nxt_tbl[p[IDX_W-1:0]] = n;
          if (pool_head == LINK_W'(idx)) pool_head = n;
          if (pool_tail == LINK_W'(idx)) pool_tail = p;
          if (free_top < SLOTS) begin
            free_stk[free_top] = idx;
            free_top++;
          end
          free_map[idx] = 1'b1;
          pool_live--;
          a.status = STAT_OK;
        end
      end
      CMD_LOOKUP: begin
        if (handle_live(idx, g)) begin
          a.status  = STAT_OK;
          a.payload = pay_tbl[idx];
        end
      end
      CMD_NEXT, CMD_PREV: begin
        if (pool_live != 0) begin
          a.status = STAT_OK;
          a.index  = (cmd == CMD_NEXT) ? nxt_tbl[idx] : prv_tbl[idx];
        end
      end
      default: ;
    endcase
    a.head  = pool_head;
    a.tail  = pool_tail;
    a.count = LINK_W'(pool_live);
    answers_due.push_back(a);
  endtask

  task automatic send_beat(logic [2:0] cmd, logic [IDX_W-1:0] idx,
                           logic [GEN_W-1:0] g, logic [31:0] pay);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_command           <= cmd;
    in_slot_index        <= idx;
    in_handle_generation <= g;
    in_payload           <= pay;
    do @(posedge clk); while (in_stall);
    predict_pool(cmd, idx, g, pay);
    beats_sent++;
  endtask

  task automatic pause_sender();
    in_valid <= 1'b0;
    wait (answers_due.size() == 0);
    repeat (6) @(posedge clk);
  endtask

  // live handle where one exists, else a random one
  task automatic pick_handle(output logic [IDX_W-1:0] idx, output logic [GEN_W-1:0] g);
    int start;
    idx = IDX_W'($urandom_range(255));
    g   = gen_tbl[idx];
    if (pool_live == 0) return;
    start = $urandom_range(255);
    for (int k = 0; k < SLOTS; k++) begin
      if (!free_map[(start + k) % SLOTS]) begin
        idx = IDX_W'((start + k) % SLOTS);
        g   = gen_tbl[idx];
        return;
      end
    end
  endtask

  task automatic test_empty_pool();
    send_beat(CMD_REMOVE, 8'd0, 8'd0, '0);
    send_beat(CMD_LOOKUP, 8'd255, 8'd255, '0);
    send_beat(CMD_NEXT, 8'd0, 8'd0, '0);
    send_beat(CMD_PREV, 8'd255, 8'd0, '0);
    send_beat(CMD_RSV5, 8'd3, 8'd1, 32'hFFFF_FFFF);
    send_beat(CMD_RSV6, 8'd0, 8'd0, '0);
    send_beat(CMD_RSV7, 8'd255, 8'd255, 32'hA5A5_5A5A);
  endtask

  task automatic test_list_ops();
    send_beat(CMD_ADD, 8'd0, 8'd0, 32'h0000_0000);
    send_beat(CMD_ADD, 8'd255, 8'd255, 32'hFFFF_FFFF);
    send_beat(CMD_ADD, 8'd0, 8'd0, 32'h1234_5678);
    send_beat(CMD_LOOKUP, 8'd1, 8'd1, '0);
    send_beat(CMD_LOOKUP, 8'd1, 8'd2, '0);
    send_beat(CMD_LOOKUP, 8'd0, 8'd0, '0);
    send_beat(CMD_NEXT, 8'd1, 8'd0, '0);
    send_beat(CMD_PREV, 8'd1, 8'd0, '0);
    send_beat(CMD_REMOVE, 8'd1, 8'd1, '0);
    send_beat(CMD_LOOKUP, 8'd1, 8'd1, '0);
    send_beat(CMD_NEXT, 8'd1, 8'd0, '0);
    send_beat(CMD_NEXT, 8'd0, 8'd0, '0);
    send_beat(CMD_REMOVE, 8'd0, 8'd1, '0);
    send_beat(CMD_REMOVE, 8'd2, 8'd1, '0);
    send_beat(CMD_REMOVE, 8'd2, 8'd1, '0);
    send_beat(CMD_RSV5, 8'd0, 8'd0, '0);
  endtask

  task automatic test_full_pool();
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] g;
    while (pool_live < SLOTS) send_beat(CMD_ADD, '0, '0, $urandom);
    send_beat(CMD_ADD, '0, '0, $urandom);
    send_beat(CMD_NEXT, 8'd255, '0, '0);
    send_beat(CMD_PREV, 8'd0, '0, '0);
    while (pool_live > 0) begin
      pick_handle(idx, g);
      send_beat(CMD_REMOVE, idx, g, '0);
    end
    pause_sender();
  endtask

  task automatic test_random_churn(int beats, int cap);
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] g;
    int               roll;
    for (int b = 0; b < beats; b++) begin
      pick_handle(idx, g);
      if ($urandom_range(99) < 15) begin
        idx = IDX_W'($urandom);
        g   = GEN_W'($urandom);
      end
      roll = $urandom_range(99);
      if (pool_live >= cap) roll = roll / 2 + 40;
      if (roll < 36)      send_beat(CMD_ADD, IDX_W'($urandom), GEN_W'($urandom), $urandom);
      else if (roll < 62) send_beat(CMD_REMOVE, idx, g, $urandom);
      else if (roll < 80) send_beat(CMD_LOOKUP, idx, g, $urandom);
      else if (roll < 88) send_beat(CMD_NEXT, idx, g, $urandom);
      else if (roll < 96) send_beat(CMD_PREV, idx, g, $urandom);
      else                send_beat(3'($urandom_range(5, 7)), idx, g, $urandom);
    end
  endtask

  task automatic test_backpressure();
    pause_sender();
    send_idle_pct = 0;
    hold_left = 300;
    test_random_churn(30, 8);
    send_idle_pct = 29;
    pause_sender();
  endtask

  task automatic test_no_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_churn(250, 20);
    send_idle_pct  = 29;
    recv_stall_pct = 29;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t %s: expected %0h, actual %0h", $realtime, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    pool_answer_t a;
    if (rst_n && out_valid && !out_stall) begin
      if (answers_due.size() == 0) begin
        $display("%0t unexpected result beat: expected none, actual status %0h",
                 $realtime, out_status);
        errors++;
      end else begin
        a = answers_due.pop_front();
        check_field("status", a.status, out_status);
        check_field("result_index", a.index, out_result_index);
        check_field("result_generation", a.gen, out_result_generation);
        check_field("result_payload", a.payload, out_result_payload);
        check_field("head_index", a.head, out_head_index);
        check_field("tail_index", a.tail, out_tail_index);
        check_field("live_count", a.count, out_live_count);
        beats_checked++;
      end
    end
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      free_stk[i] = IDX_W'(SLOTS - 1 - i);
      free_map[i] = 1'b1;
      gen_tbl[i]  = '0;
      nxt_tbl[i]  = NONE_IDX;
      prv_tbl[i]  = NONE_IDX;
      pay_tbl[i]  = '0;
    end
    free_top  = SLOTS;
    pool_head = NONE_IDX;
    pool_tail = NONE_IDX;
    pool_live = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_pool();
    test_list_ops();
    test_backpressure();
    test_random_churn(500, 6);
    test_no_idle();
    test_full_pool();
    test_random_churn(500, 200);
    pause_sender();
    repeat (10) @(posedge clk);
    $display("Covered %0d beats checked of %0d sent: full pool, %0d full rejects,",
             beats_checked, beats_sent, full_hits);
    $display("%0d generation wraps, long receiver hold-off and stretches without idling.",
             gen_wraps);
    if (errors == 0 && answers_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
